// ----- hw/rtl/dqs_pkg.sv -----
// Shared constants, field widths, codes and ring arithmetic for the integer deque with search.
package dqs_pkg;

  localparam int DEPTH = 32;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  localparam int OPCODE_W    = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 6;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Ring position of the entry that lies off places behind base; off never reaches DEPTH.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/dqs_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module dqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/integer_deque_with_search_unit.sv -----
// Bounded double-ended queue of signed integers held in a ring in one RAM, with linear search.
// The block takes one transaction at a time and returns exactly one result for each. Pushes, pops
// and unused opcodes pass through the done state to the result register. A search walks the
// held entries through the single RAM read port, one entry per cycle, and stops at the first
// match or after the last entry, and an empty queue skips the walk. A result waiting
// in the output register holds back only the following result, not the work on it.
module integer_deque_with_search_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dqs_pkg::IN_TDATA_W-1:0]  in_tdata,   // value [31:0], zero padding [39:32]
  input  logic [dqs_pkg::OPCODE_W-1:0]    in_tuser,   // opcode [2:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dqs_pkg::OUT_TDATA_W-1:0] out_tdata   // status [1:0], found [2], count [8:3],
                                                      // zero padding [15:9]
);
  import dqs_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_DONE   = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       iss_r, iss_nxt;
  logic [VALUE_W-1:0]     key_r, key_nxt;
  logic [STATUS_W-1:0]    st_r, st_nxt;
  logic                   fnd_r, fnd_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                   accept;
  logic [OPCODE_W-1:0]    opcode;
  logic [VALUE_W-1:0]     value;
  logic [COUNT_W-1:0]     cnt_field;
  logic                   ram_we;
  logic [PTR_W-1:0]       ram_waddr;
  logic [VALUE_W-1:0]     ram_wdata;
  logic [PTR_W-1:0]       ram_raddr;
  logic [VALUE_W-1:0]     ram_rdata;

  assign opcode    = in_tuser;
  assign value     = in_tdata[VALUE_W-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cnt_field = COUNT_W'(cnt_r);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    key_nxt       = key_r;
    st_nxt        = st_r;
    fnd_nxt       = fnd_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = head_r;
    ram_wdata     = value;
    ram_raddr     = head_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt   = value;
          st_nxt    = ST_DONE;
          fnd_nxt   = 1'b0;
          state_nxt = S_DONE;
          unique case (opcode)
            OP_PUSH_FRONT: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                head_nxt  = (head_r == '0) ? PTR_W'(DEPTH - 1) : head_r - 1'b1;
                ram_we    = 1'b1;
                ram_waddr = head_nxt;
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (cnt_r == CNT_W'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ring_add(head_r, cnt_r);
                cnt_nxt   = cnt_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                head_nxt = ring_add(head_r, CNT_W'(1));
                cnt_nxt  = cnt_r - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            OP_SEARCH: begin
              if (cnt_r != '0) begin
                ram_raddr = head_r;
                iss_nxt   = CNT_W'(1);
                state_nxt = S_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        // The word read in the previous cycle is compared while the next read is issued.
        if (ram_rdata == key_r) begin
          fnd_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else if (iss_r == cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          ram_raddr = ring_add(head_r, iss_r);
          iss_nxt   = iss_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({cnt_field, fnd_r, st_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r      <= iss_nxt;
    key_r      <= key_nxt;
    st_r       <= st_nxt;
    fnd_r      <= fnd_nxt;
    out_data_r <= out_data_nxt;
  end

  dqs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hw/rtl/dqs_checker.sv -----
// Port-level checker for the integer deque with search, bound to the top level.
module dqs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dqs_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dqs_pkg::*;

  logic [STATUS_W-1:0] status;
  logic                found;
  logic [COUNT_W-1:0]  count;

  assign status = out_tdata[STATUS_W-1:0];
  assign found  = out_tdata[STATUS_W];
  assign count  = out_tdata[STATUS_W+COUNT_W:STATUS_W+1];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("A result was withdrawn or changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("A transaction was accepted while the previous one was still at work.");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && found |-> status == ST_DONE)
    else $error("A result reports a match together with an error status.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == ST_FULL |-> count == COUNT_W'(DEPTH))
    else $error("A full status was reported while the queue was not full.");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == ST_EMPTY |-> count == '0)
    else $error("An empty status was reported while the queue held entries.");

endmodule

bind integer_deque_with_search_unit dqs_checker u_dqs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- tb/integer_deque_with_search_unit_tb.sv -----
// Self-checking testbench for the integer deque with search, driven through its stream ports.
module integer_deque_with_search_unit_tb;
  import dqs_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYCLES = DEPTH + 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [COUNT_W-1:0]  count;
  } deque_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OPCODE_W-1:0]    in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [VALUE_W-1:0] model_words [DEPTH];
  int                 model_head  = 0;
  int                 model_count = 0;
  deque_result_t      pending_results [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_request   = 0;
  int hold_left      = 0;

  integer_deque_with_search_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic deque_result_t step_deque_model(input logic [OPCODE_W-1:0] op,
                                                     input logic [VALUE_W-1:0]  value);
    deque_result_t res;
    res        = '0;
    res.status = ST_DONE;
    case (op)
      OP_PUSH_FRONT: begin
        if (model_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          model_head = (model_head + DEPTH - 1) % DEPTH;
          model_words[model_head] = value;
          model_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (model_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          model_words[(model_head + model_count) % DEPTH] = value;
          model_count++;
        end
      end
      OP_POP_FRONT: begin
        if (model_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          model_head = (model_head + 1) % DEPTH;
          model_count--;
        end
      end
      OP_POP_BACK: begin
        if (model_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          model_count--;
        end
      end
      OP_SEARCH: begin
        for (int i = 0; i < model_count; i++) begin
          if (model_words[(model_head + i) % DEPTH] == value) begin
            res.found = 1'b1;
            break;
          end
        end
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(model_count);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction waiting", 32'(out_tdata), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[1:0] !== want.status) begin
          report_mismatch("status", 32'(out_tdata[1:0]), 32'(want.status));
        end
        if (out_tdata[2] !== want.found) begin
          report_mismatch("found", 32'(out_tdata[2]), 32'(want.found));
        end
        if (out_tdata[8:3] !== want.count) begin
          report_mismatch("count", 32'(out_tdata[8:3]), 32'(want.count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - VALUE_W){1'b0}}, value};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(step_deque_model(op, value));
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(input logic [OPCODE_W-1:0] op);
    int r;
    if (op == OP_SEARCH && model_count > 0 && $urandom_range(99) < 60) begin
      return model_words[(model_head + $urandom_range(model_count - 1)) % DEPTH];
    end
    r = $urandom_range(99);
    if (r < 10) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return '1;
        default: return '0;
      endcase
    end else if (r < 35) begin
      return VALUE_W'($urandom_range(15)) ^ ($urandom_range(1) ? '1 : '0);
    end
    return $urandom;
  endfunction

  task automatic send_random_items(input int n, input int push_pct);
    logic [OPCODE_W-1:0] op;
    int                  r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 4) begin
        op = OPCODE_W'($urandom_range(7, 5));
      end else if (r < 28) begin
        op = OP_SEARCH;
      end else if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      send_item(op, pick_value(op));
    end
  endtask

  task automatic test_directed_cases();
    send_item(OP_POP_FRONT, 32'h1234_5678);
    send_item(OP_POP_BACK, '1);
    send_item(OP_SEARCH, '0);
    send_item(3'd5, 32'hFFFF_FFFF);
    send_item(3'd6, 32'h0000_0000);
    send_item(3'd7, 32'hAAAA_5555);
    send_item(OP_PUSH_FRONT, 32'h8000_0000);
    send_item(OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_item(OP_PUSH_FRONT, '0);
    send_item(OP_PUSH_BACK, '1);
    send_item(OP_SEARCH, 32'h8000_0000);
    send_item(OP_SEARCH, 32'h7FFF_FFFF);
    send_item(OP_SEARCH, 32'h0000_0001);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_SEARCH, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_SEARCH, '1);
    send_item(3'd7, '1);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_SEARCH, 32'h8000_0000);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    send_random_items(200, 85);
    send_random_items(200, 15);
    send_random_items(200, 55);
    wait_for_drain();
  endtask

  task automatic test_receiver_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 400;
    send_random_items(40, 70);
    wait_for_drain();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_random_items(15, 60);
    wait_for_drain();
    send_random_items(15, 40);
    wait_for_drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(36, 66);
    test_random_traffic(66, 36);
    test_random_traffic(0, 0);
    test_receiver_hold_off();
    test_sender_pause();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
